/* hdl/bole_pkg.sv */
// ----------------------------------------------------------------------------
// bole_pkg
// shared types and constants of the bounded ordered list engine
// ----------------------------------------------------------------------------
package bole_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LOG_N    = IDX_W;

    localparam int VAL_W    = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_ORD   = 3'd1;
    localparam logic [OP_W-1:0] OP_SEARCH    = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic load_op;
        logic take_left;
        logic take_right;
    } cell_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                is_empty;
        logic [COUNT_W-1:0]  element_count;
        logic [POS_W-1:0]    match_position;
        logic                found;
    } result_t;

endpackage

/* hdl/bounded_ordered_list_engine.sv */
// At the accept edge every cell compares its value with the operand in
// parallel. At the edge where the item fires, the first-hit logic picks
// the point of action, all cells shift or load at once, and the result
// item is written into the output register. The next item can be
// accepted after that, so only one item is in work at a time. The item
// fires only once the output register no longer holds a result that has
// not been taken, since the list cannot update until then.
// Capacity is set in the package.
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine
// bounded list of signed values with insert, ordered insert, clear, search, remove
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // operand_value
    input  logic [2:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // found, match_position, element_count, is_empty, status
);

    localparam int N = bole_pkg::CAPACITY;

    logic                          busy_reg;
    logic [bole_pkg::OP_W-1:0]     op_reg;
    logic [bole_pkg::VAL_W-1:0]    operand_reg;
    logic                          out_valid_reg;
    bole_pkg::result_t             out_reg;
    logic                          s_fire;
    logic                          fire;
    logic [bole_pkg::VAL_W-1:0]    cell_value [N];
    logic [N-1:0]                  lt;
    logic [N-1:0]                  eq;
    bole_pkg::cell_cmd_t           cmd [N];
    bole_pkg::result_t             result;
    logic [bole_pkg::CNT_W-1:0]    count;

    assign s_axis_tready = !busy_reg;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign fire          = busy_reg && (!out_valid_reg || m_axis_tready);

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            bole_cell u_cell
            (
                .clk         (clk),
                .capture     (s_fire),
                .cmp_value   (s_axis_tdata),
                .operand     (operand_reg),
                .left_value  ((g == 0) ? operand_reg : cell_value[(g == 0) ? 0 : g - 1]),
                .right_value ((g == N - 1) ? cell_value[g] : cell_value[(g == N - 1) ? g : g + 1]),
                .cmd         (cmd[g]),
                .value       (cell_value[g]),
                .lt          (lt[g]),
                .eq          (eq[g])
            );
        end
    endgenerate

    bole_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .op     (op_reg),
        .lt     (lt),
        .eq     (eq),
        .cmd    (cmd),
        .result (result),
        .count  (count)
    );

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            op_reg      <= s_axis_tuser;
            operand_reg <= s_axis_tdata;
        end
        if (fire)
        begin
            out_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                busy_reg <= 1'b1;
            end
            else if (fire)
            begin
                busy_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= bole_pkg::CNT_W'(N))
        else $error("element count above capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_axis_tready)
        else $error("item accepted while previous still in work");

    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.found) |-> (out_reg.status == bole_pkg::ST_DONE))
        else $error("found with fault status");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_reg.is_empty == (out_reg.element_count == '0)))
        else $error("empty flag disagrees with count");
`endif

endmodule

/* hdl/bole_cell.sv */
// ----------------------------------------------------------------------------
// bole_cell
// one list slot: holds a value, compares it with the operand, shifts
// ----------------------------------------------------------------------------
module bole_cell
(
    input  logic                          clk,
    input  logic                          capture,
    input  logic [bole_pkg::VAL_W-1:0]    cmp_value,
    input  logic [bole_pkg::VAL_W-1:0]    operand,
    input  logic [bole_pkg::VAL_W-1:0]    left_value,
    input  logic [bole_pkg::VAL_W-1:0]    right_value,
    input  bole_pkg::cell_cmd_t           cmd,
    output logic [bole_pkg::VAL_W-1:0]    value,
    output logic                          lt,
    output logic                          eq
);

    logic [bole_pkg::VAL_W-1:0] value_reg;
    logic [bole_pkg::VAL_W-1:0] value_next;
    logic                       lt_reg;
    logic                       eq_reg;

    always_comb
    begin
        if (cmd.load_op)
        begin
            value_next = operand;
        end
        else if (cmd.take_left)
        begin
            value_next = left_value;
        end
        else if (cmd.take_right)
        begin
            value_next = right_value;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (capture)
        begin
            lt_reg <= $signed(value_reg) < $signed(cmp_value);
            eq_reg <= value_reg == cmp_value;
        end
    end

    assign value = value_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

/* hdl/bole_ctrl.sv */
// ----------------------------------------------------------------------------
// bole_ctrl
// element count, first-hit search over the cell flags and cell commands
// ----------------------------------------------------------------------------
module bole_ctrl
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  logic [bole_pkg::OP_W-1:0]       op,
    input  logic [bole_pkg::CAPACITY-1:0]   lt,
    input  logic [bole_pkg::CAPACITY-1:0]   eq,
    output bole_pkg::cell_cmd_t             cmd [bole_pkg::CAPACITY],
    output bole_pkg::result_t               result,
    output logic [bole_pkg::CNT_W-1:0]      count
);

    localparam int N = bole_pkg::CAPACITY;

    logic [bole_pkg::CNT_W-1:0] count_reg;
    logic [bole_pkg::CNT_W-1:0] count_next;
    logic [N-1:0]               occ;
    logic [N-1:0]               hit;
    logic [N-1:0]               pre [bole_pkg::LOG_N+1];
    logic [N-1:0]               past;
    logic [N-1:0]               here;
    logic [bole_pkg::IDX_W-1:0] idx;
    logic                       any;
    logic                       is_ins;
    logic                       is_look;
    logic                       full;
    logic                       apply_ins;
    logic                       apply_rem;
    logic                       found;

    assign is_ins  = (op == bole_pkg::OP_INS_FRONT) || (op == bole_pkg::OP_INS_ORD);
    assign is_look = (op == bole_pkg::OP_SEARCH) || (op == bole_pkg::OP_REMOVE);
    assign full    = count_reg == bole_pkg::CNT_W'(N);

    // hit flag per cell, first hit marks the point of action
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            occ[i] = bole_pkg::CNT_W'(i) < count_reg;
            case (op)
                bole_pkg::OP_INS_FRONT: hit[i] = 1'b1;
                bole_pkg::OP_INS_ORD:   hit[i] = !(lt[i] && occ[i]);
                bole_pkg::OP_SEARCH,
                bole_pkg::OP_REMOVE:    hit[i] = eq[i] && occ[i];
                default:                hit[i] = 1'b0;
            endcase
        end
    end

    // log-depth prefix or
    always_comb
    begin
        pre[0] = hit;
        for (int s = 0; s < bole_pkg::LOG_N; s++)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (i >= (1 << s))
                begin
                    pre[s+1][i] = pre[s][i] | pre[s][i - (1 << s)];
                end
                else
                begin
                    pre[s+1][i] = pre[s][i];
                end
            end
        end
    end

    always_comb
    begin
        past[0] = 1'b0;
        for (int i = 1; i < N; i++)
        begin
            past[i] = pre[bole_pkg::LOG_N][i-1];
        end
        here = hit & ~past;
        any  = pre[bole_pkg::LOG_N][N-1];
        idx  = '0;
        for (int i = 0; i < N; i++)
        begin
            if (here[i])
            begin
                idx = idx | bole_pkg::IDX_W'(i);
            end
        end
    end

    assign apply_ins = is_ins && !full;
    assign apply_rem = (op == bole_pkg::OP_REMOVE) && any;
    assign found     = is_look && any;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            cmd[i].load_op    = fire && apply_ins && here[i];
            cmd[i].take_left  = fire && apply_ins && past[i];
            cmd[i].take_right = fire && apply_rem && (here[i] || past[i]);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (apply_ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (apply_rem)
        begin
            count_next = count_reg - 1'b1;
        end
        else if (op == bole_pkg::OP_CLEAR)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (fire)
        begin
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        result.found          = found;
        result.match_position = found ? bole_pkg::POS_W'(idx) : '0;
        result.element_count  = bole_pkg::COUNT_W'(count_next);
        result.is_empty       = count_next == '0;
        if (is_ins && full)
        begin
            result.status = bole_pkg::ST_FULL;
        end
        else if (is_look && !any)
        begin
            result.status = bole_pkg::ST_NOT_FOUND;
        end
        else
        begin
            result.status = bole_pkg::ST_DONE;
        end
    end

    assign count = count_reg;

endmodule

/* test/tb_bounded_ordered_list_engine.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_ordered_list_engine
// self-checking bench for the bounded ordered list engine: a directed run
// over the list operations and corner values, then random runs that fill,
// drain and mix the list, all checked field by field against a list model
// ----------------------------------------------------------------------------
module tb_bounded_ordered_list_engine;

    localparam logic [bole_pkg::OP_W-1:0]  OP_UNUSED_LO = bole_pkg::OP_CLEAR + 1'b1;
    localparam logic [bole_pkg::OP_W-1:0]  OP_UNUSED_HI = {bole_pkg::OP_W{1'b1}};
    localparam logic [bole_pkg::VAL_W-1:0] VAL_MIN      = 32'h8000_0000;
    localparam logic [bole_pkg::VAL_W-1:0] VAL_MAX      = 32'h7fff_ffff;
    localparam int                         ITEM_TARGET  = 1700;

    // list model and store of expected results
    class list_scoreboard;
        logic [bole_pkg::VAL_W-1:0] entries [bole_pkg::CAPACITY];
        int                         held;
        bole_pkg::result_t          expected_q [$];
        int                         errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [bole_pkg::VAL_W-1:0] held_value();
            return entries[$urandom_range(0, held - 1)];
        endfunction

        function void note_input(logic [bole_pkg::OP_W-1:0] op,
                                 logic [bole_pkg::VAL_W-1:0] val);
            bole_pkg::result_t r;
            int                at;
            int                i;
            r  = '0;
            at = 0;
            case (op)
                bole_pkg::OP_INS_FRONT, bole_pkg::OP_INS_ORD:
                begin
                    if (held >= bole_pkg::CAPACITY)
                    begin
                        r.status = bole_pkg::ST_FULL;
                    end
                    else
                    begin
                        if (op == bole_pkg::OP_INS_ORD)
                        begin
                            while (at < held && $signed(entries[at]) < $signed(val))
                                at++;
                        end
                        for (i = held; i > at; i--)
                            entries[i] = entries[i - 1];
                        entries[at] = val;
                        held++;
                    end
                end
                bole_pkg::OP_SEARCH, bole_pkg::OP_REMOVE:
                begin
                    while (at < held && entries[at] != val)
                        at++;
                    if (at < held)
                    begin
                        r.found          = 1'b1;
                        r.match_position = at[bole_pkg::POS_W-1:0];
                        if (op == bole_pkg::OP_REMOVE)
                        begin
                            for (i = at; i + 1 < held; i++)
                                entries[i] = entries[i + 1];
                            held--;
                        end
                    end
                    else
                    begin
                        r.status = bole_pkg::ST_NOT_FOUND;
                    end
                end
                bole_pkg::OP_CLEAR:
                begin
                    held = 0;
                end
                default:
                begin
                end
            endcase
            r.element_count = held[bole_pkg::COUNT_W-1:0];
            r.is_empty      = (held == 0);
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned e, int unsigned a);
            if (e != a)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(logic [15:0] data);
            bole_pkg::result_t got;
            bole_pkg::result_t exp_r;
            got = bole_pkg::result_t'(data[$bits(bole_pkg::result_t)-1:0]);
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing pending, expected none, actual %h",
                         $time, data);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            compare_field("found", 32'(exp_r.found), 32'(got.found));
            compare_field("match_position", 32'(exp_r.match_position),
                          32'(got.match_position));
            compare_field("element_count", 32'(exp_r.element_count),
                          32'(got.element_count));
            compare_field("is_empty", 32'(exp_r.is_empty), 32'(got.is_empty));
            compare_field("status", 32'(exp_r.status), 32'(got.status));
        endfunction
    endclass

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [bole_pkg::VAL_W-1:0]  s_axis_tdata  = '0;
    logic [bole_pkg::OP_W-1:0]   s_axis_tuser  = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [15:0]                 m_axis_tdata;

    list_scoreboard    sb = new();
    bit                src_busy  = 1'b1;
    bit                sink_busy = 1'b1;
    int                n_sent    = 0;

    bounded_ordered_list_engine dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic send_item(input logic [bole_pkg::OP_W-1:0] op,
                             input logic [bole_pkg::VAL_W-1:0] val);
        int gap;
        bit hs;
        gap = src_busy ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= op;
        do
        begin
            @(negedge clk);
            hs = s_axis_tready;
            @(posedge clk);
        end
        while (!hs);
        sb.note_input(op, val);
        n_sent++;
    endtask

    task automatic drain_results();
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [bole_pkg::VAL_W-1:0] pick_value();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4 && sb.held > 0)
            return sb.held_value();
        if (k < 7)
        begin
            case ($urandom_range(0, 5))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                default: return $urandom_range(0, 8) - 4;
            endcase
        end
        return $urandom;
    endfunction

    // mode 0 fills, 1 drains, 2 mixes
    function automatic logic [bole_pkg::OP_W-1:0] pick_op(int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0:
            begin
                if (r < 45) return bole_pkg::OP_INS_ORD;
                if (r < 75) return bole_pkg::OP_INS_FRONT;
                if (r < 85) return bole_pkg::OP_SEARCH;
                if (r < 94) return bole_pkg::OP_REMOVE;
                if (r < 98)
                    return bole_pkg::OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
                return bole_pkg::OP_CLEAR;
            end
            1:
            begin
                if (r < 15) return bole_pkg::OP_INS_ORD;
                if (r < 25) return bole_pkg::OP_INS_FRONT;
                if (r < 50) return bole_pkg::OP_SEARCH;
                if (r < 95) return bole_pkg::OP_REMOVE;
                if (r < 98)
                    return bole_pkg::OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
                return bole_pkg::OP_CLEAR;
            end
            default:
            begin
                if (r < 25) return bole_pkg::OP_INS_ORD;
                if (r < 45) return bole_pkg::OP_INS_FRONT;
                if (r < 65) return bole_pkg::OP_SEARCH;
                if (r < 90) return bole_pkg::OP_REMOVE;
                if (r < 95)
                    return bole_pkg::OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
                return bole_pkg::OP_CLEAR;
            end
        endcase
    endfunction

    // result side
    initial
    begin
        int          stall;
        bit          hs;
        logic [15:0] data;
        @(posedge rst_n);
        forever
        begin
            stall = sink_busy ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                hs   = m_axis_tvalid;
                data = m_axis_tdata;
                @(posedge clk);
            end
            while (!hs);
            sb.check_result(data);
        end
    end

    initial
    begin
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int                         seg;
        int                         seg_len;
        int                         mode;
        logic [bole_pkg::OP_W-1:0]  op;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, signed ordering, duplicates, hits and misses
        send_item(bole_pkg::OP_SEARCH, VAL_MIN);
        send_item(bole_pkg::OP_REMOVE, '0);
        send_item(bole_pkg::OP_INS_ORD, '0);
        send_item(bole_pkg::OP_INS_ORD, VAL_MAX);
        send_item(bole_pkg::OP_INS_ORD, VAL_MIN);
        send_item(bole_pkg::OP_INS_ORD, '1);
        send_item(bole_pkg::OP_INS_ORD, '0);
        send_item(bole_pkg::OP_INS_FRONT, VAL_MAX);
        send_item(bole_pkg::OP_SEARCH, VAL_MAX);
        send_item(bole_pkg::OP_SEARCH, '0);
        send_item(bole_pkg::OP_SEARCH, 32'd1);
        send_item(bole_pkg::OP_REMOVE, VAL_MAX);
        send_item(bole_pkg::OP_REMOVE, 32'd1);
        send_item(bole_pkg::OP_REMOVE, '0);
        for (op = OP_UNUSED_LO; op != bole_pkg::OP_INS_FRONT; op++)
            send_item(op, '1);
        send_item(bole_pkg::OP_CLEAR, $urandom);
        send_item(bole_pkg::OP_SEARCH, '0);
        send_item(bole_pkg::OP_INS_FRONT, 32'h5555_5555);
        send_item(bole_pkg::OP_INS_ORD, 32'haaaa_aaaa);
        send_item(bole_pkg::OP_CLEAR, '0);

        // random runs
        seg = 0;
        while (n_sent < ITEM_TARGET)
        begin
            mode      = $urandom_range(0, 2);
            seg_len   = (mode == 0) ? $urandom_range(60, 150) : $urandom_range(40, 120);
            src_busy  = ($urandom_range(0, 3) != 0);
            sink_busy = ($urandom_range(0, 3) != 0);
            repeat (seg_len)
            begin
                op = pick_op(mode);
                send_item(op, pick_value());
            end
            if (seg == 0 || $urandom_range(0, 3) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                drain_results();
            end
            seg++;
        end

        s_axis_tvalid <= 1'b0;
        drain_results();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
